>>> design/b64d_pkg.sv
// Shared types, constants and the character classifier for the base64 stream decoder.
package b64d_pkg;

    localparam int COUNT_BITS_DEFAULT = 16;
    localparam int QUEUE_DEPTH        = 2;
    localparam int OUT_COUNT_W        = 16;

    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;
    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_SLASH   = 8'h2F;
    localparam logic [7:0] CHAR_PAD     = 8'h3D;
    localparam logic [7:0] CHAR_TAB     = 8'h09;
    localparam logic [7:0] CHAR_LF      = 8'h0A;
    localparam logic [7:0] CHAR_CR      = 8'h0D;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_NUL     = 8'h00;

    localparam logic [7:0] LOWER_OFFSET = 8'd26;
    localparam logic [7:0] DIGIT_OFFSET = 8'd52;
    localparam logic [5:0] SEXTET_PLUS  = 6'd62;
    localparam logic [5:0] SEXTET_SLASH = 6'd63;

    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_END  = 2'd1,
        KIND_ERR  = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        CH_DATA,
        CH_PAD,
        CH_SKIP,
        CH_NUL,
        CH_ILLEGAL
    } char_kind_t;

    typedef struct packed {
        char_kind_t kind;
        logic [5:0] sextet;
    } char_class_t;

    // One decoded command: up to three bytes of a group, then an end or error marker.
    typedef struct packed {
        logic [23:0] word;
        logic [1:0]  nbytes;
        logic        emit_end;
        logic        emit_err;
    } cmd_t;

    localparam int CMD_W = $bits(cmd_t);

    function automatic char_class_t classify(input logic [7:0] c);
        char_class_t r;
        r.kind   = CH_ILLEGAL;
        r.sextet = 6'd0;
        case (c) inside
            [CHAR_UPPER_A:CHAR_UPPER_Z]:
            begin
                r.kind   = CH_DATA;
                r.sextet = 6'(c - CHAR_UPPER_A);
            end
            [CHAR_LOWER_A:CHAR_LOWER_Z]:
            begin
                r.kind   = CH_DATA;
                r.sextet = 6'(c - CHAR_LOWER_A + LOWER_OFFSET);
            end
            [CHAR_ZERO:CHAR_NINE]:
            begin
                r.kind   = CH_DATA;
                r.sextet = 6'(c - CHAR_ZERO + DIGIT_OFFSET);
            end
            CHAR_PLUS:
            begin
                r.kind   = CH_DATA;
                r.sextet = SEXTET_PLUS;
            end
            CHAR_SLASH:
            begin
                r.kind   = CH_DATA;
                r.sextet = SEXTET_SLASH;
            end
            CHAR_PAD:
            begin
                r.kind = CH_PAD;
            end
            CHAR_TAB, CHAR_LF, CHAR_CR, CHAR_SPACE:
            begin
                r.kind = CH_SKIP;
            end
            CHAR_NUL:
            begin
                r.kind = CH_NUL;
            end
            default:
            begin
                r.kind = CH_ILLEGAL;
            end
        endcase
        return r;
    endfunction

endpackage

>>> design/b64d_front.sv
// Front end: classifies characters, assembles groups and tracks the message byte count.
module b64d_front import b64d_pkg::*; #(
    parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  logic [7:0]            text_char,
    input  logic                  end_of_text,
    output logic                  q_push,
    output cmd_t                  cmd,
    output logic [COUNT_BITS-1:0] cmd_base
);

    logic [17:0]           hold_reg, hold_next;
    logic [1:0]            pos_reg, pos_next;
    logic [1:0]            pad_reg, pad_next;
    logic [COUNT_BITS-1:0] total_reg, total_next;
    logic                  err_reg, err_next;

    char_class_t           cls;
    logic                  end_evt;
    logic [5:0]            sx;
    logic [1:0]            pad_upd;
    logic [1:0]            grp_nb;
    logic [COUNT_BITS:0]   total_sum;
    logic [COUNT_BITS-1:0] total_sat;

    assign cls     = classify(text_char);
    assign end_evt = end_of_text || (cls.kind == CH_NUL);
    assign sx      = (cls.kind == CH_DATA) ? cls.sextet : 6'd0;
    assign pad_upd = ((cls.kind == CH_PAD) && (pad_reg != 2'd3)) ? pad_reg + 2'd1 : pad_reg;
    assign grp_nb  = 2'd3 - pad_upd;

    // The carry out of the add means the count went past its all-ones limit.
    assign total_sum = {1'b0, total_reg} + (COUNT_BITS + 1)'(grp_nb);
    assign total_sat = total_sum[COUNT_BITS] ? {COUNT_BITS{1'b1}} : total_sum[COUNT_BITS-1:0];

    assign cmd_base = total_reg;

    always_comb
    begin
        hold_next  = hold_reg;
        pos_next   = pos_reg;
        pad_next   = pad_reg;
        total_next = total_reg;
        err_next   = err_reg;
        cmd        = '0;
        q_push     = 1'b0;
        if (accept)
        begin
            if (err_reg)
            begin
                if (end_evt)
                begin
                    hold_next  = '0;
                    pos_next   = '0;
                    pad_next   = '0;
                    total_next = '0;
                    err_next   = 1'b0;
                end
            end
            else if (cls.kind == CH_ILLEGAL)
            begin
                cmd.emit_err = 1'b1;
                q_push       = 1'b1;
                if (end_of_text)
                begin
                    hold_next  = '0;
                    pos_next   = '0;
                    pad_next   = '0;
                    total_next = '0;
                end
                else
                begin
                    err_next = 1'b1;
                end
            end
            else
            begin
                if ((cls.kind == CH_DATA) || (cls.kind == CH_PAD))
                begin
                    if (pos_reg != 2'd3)
                    begin
                        hold_next = {hold_reg[11:0], sx};
                        pos_next  = pos_reg + 2'd1;
                        pad_next  = pad_upd;
                    end
                    else
                    begin
                        cmd.word   = {hold_reg, sx};
                        cmd.nbytes = grp_nb;
                        total_next = total_sat;
                        hold_next  = '0;
                        pos_next   = '0;
                        pad_next   = '0;
                    end
                end
                if (end_evt)
                begin
                    cmd.emit_end = 1'b1;
                    hold_next    = '0;
                    pos_next     = '0;
                    pad_next     = '0;
                    total_next   = '0;
                end
                q_push = (cmd.nbytes != 2'd0) || cmd.emit_end;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg  <= '0;
            pos_reg   <= '0;
            pad_reg   <= '0;
            total_reg <= '0;
            err_reg   <= 1'b0;
        end
        else
        begin
            hold_reg  <= hold_next;
            pos_reg   <= pos_next;
            pad_reg   <= pad_next;
            total_reg <= total_next;
            err_reg   <= err_next;
        end
    end

endmodule

>>> design/b64d_queue.sv
// Small register queue that decouples the front end from the result sequencer.
module b64d_queue import b64d_pkg::*; #(
    parameter int WIDTH = CMD_W,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             pop,
    output logic             valid,
    output logic [WIDTH-1:0] rd_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full    = (cnt_reg == FULL_CNT);
    assign valid   = (cnt_reg != '0);
    assign rd_data = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

>>> design/b64d_back.sv
// Back end: issues each queued command's bytes and marker, one result per cycle unless held.
module b64d_back import b64d_pkg::*; #(
    parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_valid,
    input  cmd_t                   cmd,
    input  logic [COUNT_BITS-1:0]  cmd_base,
    output logic                   q_pop,
    output logic [7:0]             out_byte,
    output logic [1:0]             out_kind,
    output logic [OUT_COUNT_W-1:0] decoded_count,
    output logic                   run_last,
    output logic                   empty,
    input  logic                   pop
);

    logic [1:0]             idx_reg, idx_next;
    logic                   out_valid_reg, out_valid_next;
    logic [7:0]             byte_reg;
    logic [1:0]             kind_reg;
    logic [OUT_COUNT_W-1:0] count_reg;
    logic                   last_reg;

    logic                   produce;
    logic                   is_data;
    logic [1:0]             cnt_off;
    logic [COUNT_BITS:0]    cnt_sum;
    logic [COUNT_BITS-1:0]  cnt_sat;
    logic [7:0]             res_byte;
    kind_t                  res_kind;
    logic                   res_last;

    assign produce = q_valid && (!out_valid_reg || pop);
    assign is_data = (idx_reg < cmd.nbytes);

    // A data byte counts itself; the end marker carries the count after all bytes.
    assign cnt_off = is_data ? idx_reg + 2'd1 : idx_reg;
    assign cnt_sum = {1'b0, cmd_base} + (COUNT_BITS + 1)'(cnt_off);
    assign cnt_sat = cnt_sum[COUNT_BITS] ? {COUNT_BITS{1'b1}} : cnt_sum[COUNT_BITS-1:0];

    always_comb
    begin
        res_byte = 8'd0;
        res_kind = KIND_DATA;
        res_last = 1'b1;
        if (is_data)
        begin
            case (idx_reg)
                2'd0:    res_byte = cmd.word[23:16];
                2'd1:    res_byte = cmd.word[15:8];
                default: res_byte = cmd.word[7:0];
            endcase
            res_last = (idx_reg == (cmd.nbytes - 2'd1)) && !cmd.emit_end && !cmd.emit_err;
        end
        else if (cmd.emit_err)
        begin
            res_kind = KIND_ERR;
        end
        else
        begin
            res_kind = KIND_END;
        end
    end

    assign q_pop = produce && res_last;

    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (produce)
        begin
            out_valid_next = 1'b1;
            idx_next       = res_last ? 2'd0 : idx_reg + 2'd1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (produce)
        begin
            byte_reg  <= res_byte;
            kind_reg  <= res_kind;
            count_reg <= OUT_COUNT_W'(cnt_sat);
            last_reg  <= res_last;
        end
    end

    assign out_byte      = byte_reg;
    assign out_kind      = kind_reg;
    assign decoded_count = count_reg;
    assign run_last      = last_reg;
    assign empty         = !out_valid_reg;

endmodule

>>> design/base64_stream_decoder_core.sv
// A character's results pass through the command queue, then the output register.
// Throughput: one character per cycle is taken while the two-entry command queue has room.
// Results leave at one per cycle while taken; a group's bytes leave one after another.
// The front end can run ahead of the back end by the queue depth plus the output register.
// Reset clears group state, byte count, error flag, queue pointers and output valid flag.
module base64_stream_decoder_core import b64d_pkg::*; #(
    parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [7:0]             text_char,
    input  logic                   end_of_text,
    input  logic                   push,
    output logic                   full,
    output logic [7:0]             out_byte,
    output logic [1:0]             out_kind,
    output logic [OUT_COUNT_W-1:0] decoded_count,
    output logic                   run_last,
    output logic                   empty,
    input  logic                   pop
);

    localparam int QW = CMD_W + COUNT_BITS;

    logic                  accept;
    logic                  f_push;
    cmd_t                  f_cmd;
    logic [COUNT_BITS-1:0] f_base;
    logic                  q_full;
    logic                  q_valid;
    logic                  q_pop;
    logic [QW-1:0]         q_rd;
    cmd_t                  b_cmd;
    logic [COUNT_BITS-1:0] b_base;

    assign full   = q_full;
    assign accept = push && !q_full;
    assign b_cmd  = cmd_t'(q_rd[QW-1:COUNT_BITS]);
    assign b_base = q_rd[COUNT_BITS-1:0];

    b64d_front #(
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .text_char   (text_char),
        .end_of_text (end_of_text),
        .q_push      (f_push),
        .cmd         (f_cmd),
        .cmd_base    (f_base)
    );

    b64d_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (f_push),
        .wr_data ({f_cmd, f_base}),
        .full    (q_full),
        .pop     (q_pop),
        .valid   (q_valid),
        .rd_data (q_rd)
    );

    b64d_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .cmd           (b_cmd),
        .cmd_base      (b_base),
        .q_pop         (q_pop),
        .out_byte      (out_byte),
        .out_kind      (out_kind),
        .decoded_count (decoded_count),
        .run_last      (run_last),
        .empty         (empty),
        .pop           (pop)
    );

endmodule

>>> design/b64d_checker.sv
// Port-level assertions for the base64 stream decoder and the bind that attaches them.
module b64d_checker import b64d_pkg::*; (
    input logic                   clk,
    input logic                   rst_n,
    input logic [7:0]             out_byte,
    input logic [1:0]             out_kind,
    input logic [OUT_COUNT_W-1:0] decoded_count,
    input logic                   run_last,
    input logic                   empty,
    input logic                   pop
);

    // A waiting result that is not taken must not change.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> ($stable(out_byte) && $stable(out_kind)
                              && $stable(decoded_count) && $stable(run_last)))
    else $error("stalled result changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (out_kind == KIND_DATA || out_kind == KIND_END || out_kind == KIND_ERR))
    else $error("result kind out of range");

    // End and error markers always close the run of results for a character.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && out_kind != KIND_DATA) |-> run_last)
    else $error("marker not flagged as last result");

    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && out_kind != KIND_DATA) |-> (out_byte == 8'd0))
    else $error("marker carries a nonzero byte");

    // The rest of a run follows a data byte transfer at once and never holds an error.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && out_kind == KIND_DATA && !run_last)
            |=> (!empty && out_kind != KIND_ERR))
    else $error("run of results broken after a data byte");

endmodule

bind base64_stream_decoder_core b64d_checker u_b64d_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_byte      (out_byte),
    .out_kind      (out_kind),
    .decoded_count (decoded_count),
    .run_last      (run_last),
    .empty         (empty),
    .pop           (pop)
);

>>> tb/tb_base64_stream_decoder_core.sv
// Self-checking testbench for the base64 stream decoder core with directed and random text.
`timescale 1ns / 100ps

module tb_base64_stream_decoder_core;
    import b64d_pkg::*;

    typedef enum logic [2:0] {
        CC_DATA,
        CC_PAD,
        CC_BLANK,
        CC_NUL,
        CC_BAD
    } char_cls_t;

    typedef struct packed {
        logic [7:0]             data;
        kind_t                  kind;
        logic [OUT_COUNT_W-1:0] count;
        logic                   last;
    } dec_result_t;

    typedef struct packed {
        logic [7:0]             ch;
        logic                   eot;
        logic                   typed;
        kind_t                  kind;
        logic [OUT_COUNT_W-1:0] count;
    } stim_row_t;

    localparam int RANDOM_ITEMS = 340;

    logic                   clk         = 1'b0;
    logic                   rst_n       = 1'b0;
    logic [7:0]             text_char   = 8'h00;
    logic                   end_of_text = 1'b0;
    logic                   push        = 1'b0;
    logic                   pop         = 1'b0;
    logic                   full;
    logic [7:0]             out_byte;
    logic [1:0]             out_kind;
    logic [OUT_COUNT_W-1:0] decoded_count;
    logic                   run_last;
    logic                   empty;

    // Decoder state as the predictor sees it.
    logic [17:0]                   held_sextets = '0;
    logic [1:0]                    held_count   = '0;
    logic [1:0]                    pad_count    = '0;
    logic [COUNT_BITS_DEFAULT-1:0] msg_bytes    = '0;
    logic                          in_error     = 1'b0;

    dec_result_t expected_q[$];
    int          errors     = 0;
    int          live_items = 0;
    int          pop_hold   = 0;
    logic        quiet      = 1'b0;

    // Rows with a typed result give exactly one result: byte zero, last set.
    stim_row_t dir_rows [27] = '{
        '{CHAR_NUL, 1'b0, 1'b1, KIND_END,  16'd0},
        '{"A",      1'b0, 1'b0, KIND_DATA, 16'd0},
        '{"Z",      1'b0, 1'b0, KIND_DATA, 16'd0},
        '{"a",      1'b0, 1'b0, KIND_DATA, 16'd0},
        '{CHAR_TAB, 1'b0, 1'b0, KIND_DATA, 16'd0},
        '{"z",      1'b0, 1'b0, KIND_DATA, 16'd0},
        '{"0",      1'b0, 1'b0, KIND_DATA, 16'd0},
        '{CHAR_CR,  1'b0, 1'b0, KIND_DATA, 16'd0},
        '{"9",      1'b0, 1'b0, KIND_DATA, 16'd0},
        '{CHAR_LF,  1'b0, 1'b0, KIND_DATA, 16'd0},
        '{"+",      1'b0, 1'b0, KIND_DATA, 16'd0},
        '{" ",      1'b0, 1'b0, KIND_DATA, 16'd0},
        '{"/",      1'b1, 1'b0, KIND_DATA, 16'd0},
        '{CHAR_PAD, 1'b0, 1'b0, KIND_DATA, 16'd0},
        '{CHAR_PAD, 1'b0, 1'b0, KIND_DATA, 16'd0},
        '{CHAR_PAD, 1'b0, 1'b0, KIND_DATA, 16'd0},
        '{CHAR_PAD, 1'b0, 1'b0, KIND_DATA, 16'd0},
        '{"Q",      1'b0, 1'b0, KIND_DATA, 16'd0},
        '{CHAR_PAD, 1'b0, 1'b0, KIND_DATA, 16'd0},
        '{"Q",      1'b0, 1'b0, KIND_DATA, 16'd0},
        '{CHAR_PAD, 1'b1, 1'b0, KIND_DATA, 16'd0},
        '{8'hFF,    1'b0, 1'b1, KIND_ERR,  16'd0},
        '{"A",      1'b0, 1'b0, KIND_DATA, 16'd0},
        '{CHAR_NUL, 1'b0, 1'b0, KIND_DATA, 16'd0},
        '{8'h80,    1'b1, 1'b1, KIND_ERR,  16'd0},
        '{" ",      1'b1, 1'b1, KIND_END,  16'd0},
        '{CHAR_NUL, 1'b1, 1'b1, KIND_END,  16'd0}
    };

    base64_stream_decoder_core #(
        .COUNT_BITS(COUNT_BITS_DEFAULT)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .text_char    (text_char),
        .end_of_text  (end_of_text),
        .push         (push),
        .full         (full),
        .out_byte     (out_byte),
        .out_kind     (out_kind),
        .decoded_count(decoded_count),
        .run_last     (run_last),
        .empty        (empty),
        .pop          (pop)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic char_cls_t char_class(input logic [7:0] c, output logic [5:0] sx);
        sx = 6'd0;
        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z)
        begin
            sx = 6'(c - CHAR_UPPER_A);
            return CC_DATA;
        end
        if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z)
        begin
            sx = 6'(c - CHAR_LOWER_A) + 6'd26;
            return CC_DATA;
        end
        if (c >= CHAR_ZERO && c <= CHAR_NINE)
        begin
            sx = 6'(c - CHAR_ZERO) + 6'd52;
            return CC_DATA;
        end
        if (c == CHAR_PLUS)
        begin
            sx = 6'd62;
            return CC_DATA;
        end
        if (c == CHAR_SLASH)
        begin
            sx = 6'd63;
            return CC_DATA;
        end
        if (c == CHAR_PAD)
            return CC_PAD;
        if (c == CHAR_TAB || c == CHAR_CR || c == CHAR_LF || c == CHAR_SPACE)
            return CC_BLANK;
        if (c == CHAR_NUL)
            return CC_NUL;
        return CC_BAD;
    endfunction

    function automatic logic [7:0] b64_char(input int idx);
        if (idx < 26)
            return CHAR_UPPER_A + 8'(idx);
        if (idx < 52)
            return CHAR_LOWER_A + 8'(idx - 26);
        if (idx < 62)
            return CHAR_ZERO + 8'(idx - 52);
        return (idx == 62) ? CHAR_PLUS : CHAR_SLASH;
    endfunction

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(0, 3))
            0:       return CHAR_TAB;
            1:       return CHAR_LF;
            2:       return CHAR_CR;
            default: return CHAR_SPACE;
        endcase
    endfunction

    // Mostly no gap, sometimes a short one, rarely a long one.
    function automatic int pick_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 15);
        if (r < 9)
            return 0;
        if (r < 15)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic void clear_message();
        held_sextets = '0;
        held_count   = '0;
        pad_count    = '0;
        msg_bytes    = '0;
        in_error     = 1'b0;
    endfunction

    function automatic dec_result_t make_result(input logic [7:0] b, input kind_t k);
        dec_result_t r;
        r.data  = b;
        r.kind  = k;
        r.count = OUT_COUNT_W'(msg_bytes);
        r.last  = 1'b0;
        return r;
    endfunction

    function automatic void decode_char(input logic [7:0] c, input logic eot,
                                        output dec_result_t res[$]);
        char_cls_t   cls;
        logic [5:0]  sx;
        logic [23:0] word;
        logic        end_msg;
        int          nbytes;
        res.delete();
        cls     = char_class(c, sx);
        end_msg = eot || (cls == CC_NUL);
        // After an error everything is dropped until the message ends, silently.
        if (in_error)
        begin
            if (end_msg)
                clear_message();
            return;
        end
        if (cls == CC_BAD)
        begin
            res.push_back(make_result(8'h00, KIND_ERR));
            res[0].last = 1'b1;
            if (eot)
                clear_message();
            else
                in_error = 1'b1;
            return;
        end
        if (cls == CC_DATA || cls == CC_PAD)
        begin
            if (cls == CC_PAD && pad_count != 2'd3)
                pad_count++;
            if (held_count != 2'd3)
            begin
                held_sextets = {held_sextets[11:0], sx};
                held_count++;
            end
            else
            begin
                word   = {held_sextets, sx};
                nbytes = 3 - int'(pad_count);
                for (int i = 0; i < nbytes; i++)
                begin
                    if (msg_bytes != '1)
                        msg_bytes++;
                    res.push_back(make_result(word[23 - 8 * i -: 8], KIND_DATA));
                end
                held_sextets = '0;
                held_count   = '0;
                pad_count    = '0;
            end
        end
        if (end_msg)
        begin
            res.push_back(make_result(8'h00, KIND_END));
            clear_message();
        end
        if (res.size() > 0)
            res[res.size() - 1].last = 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("ERROR at %0t: %s got %0h expected %0h", $time, what, got, want);
        errors++;
    endtask

    // Drives one character and waits for its transfer, then records what it should cause.
    task automatic send_char(input logic [7:0] c, input logic eot, input logic typed,
                             input kind_t want_kind, input logic [OUT_COUNT_W-1:0] want_count);
        int          gap;
        dec_result_t res[$];
        dec_result_t typed_res;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        text_char   <= c;
        end_of_text <= eot;
        push        <= 1'b1;
        @(posedge clk);
        while (full)
            @(posedge clk);
        live_items++;
        decode_char(c, eot, res);
        if (typed)
        begin
            typed_res.data  = 8'h00;
            typed_res.kind  = want_kind;
            typed_res.count = want_count;
            typed_res.last  = 1'b1;
            expected_q.push_back(typed_res);
        end
        else
        begin
            foreach (res[i])
                expected_q.push_back(res[i]);
        end
    endtask

    always @(negedge clk)
    begin
        if (pop_hold > 0)
        begin
            pop <= 1'b0;
            pop_hold--;
        end
        else
        begin
            pop      <= 1'b1;
            pop_hold = pick_gap();
        end
    end

    always @(posedge clk)
    begin
        dec_result_t want;
        if (rst_n && pop && !empty)
        begin
            if (expected_q.size() == 0)
                report_mismatch("result transfer with nothing expected, out_kind", out_kind, 0);
            else
            begin
                want = expected_q.pop_front();
                if (out_byte !== want.data)
                    report_mismatch("out_byte", out_byte, want.data);
                if (out_kind !== want.kind)
                    report_mismatch("out_kind", out_kind, want.kind);
                if (decoded_count !== want.count)
                    report_mismatch("decoded_count", decoded_count, want.count);
                if (run_last !== want.last)
                    report_mismatch("run_last", run_last, want.last);
            end
        end
    end

    initial
    begin
        int         mode;
        int         ngroups;
        int         npads;
        int         pos;
        logic [8:0] msg[$];
        logic [7:0] ch;
        logic [5:0] sx_unused;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
            send_char(dir_rows[i].ch, dir_rows[i].eot, dir_rows[i].typed,
                      dir_rows[i].kind, dir_rows[i].count);

        // Random messages: mostly well formed, some with stray pads or a partial
        // group, some with an illegal character, some plain noise.
        live_items = 0;
        while (live_items < RANDOM_ITEMS)
        begin
            msg.delete();
            mode  = $urandom_range(0, 9);
            quiet = ($urandom_range(0, 9) == 0);
            if (mode == 9)
            begin
                repeat ($urandom_range(1, 8))
                    msg.push_back({($urandom_range(0, 7) == 0), 8'($urandom)});
            end
            else
            begin
                ngroups = ($urandom_range(0, 15) == 0) ? $urandom_range(8, 24)
                                                       : $urandom_range(0, 4);
                npads   = $urandom_range(0, 2);
                for (int g = 0; g < ngroups; g++)
                begin
                    for (int k = 0; k < 4; k++)
                    begin
                        if ($urandom_range(0, 9) == 0)
                            msg.push_back({1'b0, pick_blank()});
                        if (mode == 7 && $urandom_range(0, 5) == 0)
                            ch = CHAR_PAD;
                        else if (g == ngroups - 1 && k >= 4 - npads)
                            ch = CHAR_PAD;
                        else
                            ch = b64_char($urandom_range(0, 63));
                        msg.push_back({1'b0, ch});
                    end
                end
                if (mode == 7)
                begin
                    repeat ($urandom_range(1, 3))
                        msg.push_back({1'b0, b64_char($urandom_range(0, 63))});
                end
                if (mode == 8)
                begin
                    do
                        ch = 8'($urandom);
                    while (char_class(ch, sx_unused) != CC_BAD);
                    pos = $urandom_range(0, msg.size());
                    msg.insert(pos, {1'b0, ch});
                end
            end
            case ($urandom_range(0, 3))
                0:
                begin
                    if (msg.size() > 0)
                        msg[msg.size() - 1][8] = 1'b1;
                    else
                        msg.push_back({1'b1, CHAR_NUL});
                end
                1:       msg.push_back({1'b0, CHAR_NUL});
                2:       msg.push_back({1'b1, pick_blank()});
                default: msg.push_back({1'b1, CHAR_NUL});
            endcase
            foreach (msg[j])
                send_char(msg[j][7:0], msg[j][8], 1'b0, KIND_DATA, '0);
        end
        quiet = 1'b0;

        @(negedge clk);
        push <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("PASS base64_stream_decoder_core");
        else
            $display("FAIL base64_stream_decoder_core");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("FAIL base64_stream_decoder_core");
        $finish;
    end

endmodule

>>> filelist.f
design/b64d_pkg.sv
design/b64d_front.sv
design/b64d_queue.sv
design/b64d_back.sv
design/base64_stream_decoder_core.sv
design/b64d_checker.sv
tb/tb_base64_stream_decoder_core.sv
